// ===== hw/rtl/mrpt_pkg.sv =====
// package for the miller-rabin prime test block
// widths, base table and shared types; no dependencies
package mrpt_pkg;
    localparam int WIDTH = 64;
    localparam int NUM_BASES = 5;
    localparam int BASE_TABLE_SIZE = 12;
    localparam int BASE_COUNT = (NUM_BASES > BASE_TABLE_SIZE) ? BASE_TABLE_SIZE : NUM_BASES;
    localparam int BIDX_W = (BASE_COUNT > 1) ? $clog2(BASE_COUNT) : 1;
    localparam int BIT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mul_ctl_t;

    function automatic word_t base_value(input logic [3:0] idx);
        word_t v;
        case (idx)
            4'd0: v = word_t'(2);
            4'd1: v = word_t'(3);
            4'd2: v = word_t'(5);
            4'd3: v = word_t'(7);
            4'd4: v = word_t'(11);
            4'd5: v = word_t'(13);
            4'd6: v = word_t'(17);
            4'd7: v = word_t'(19);
            4'd8: v = word_t'(23);
            4'd9: v = word_t'(29);
            4'd10: v = word_t'(31);
            4'd11: v = word_t'(37);
            default: v = word_t'(2);
        endcase
        return v;
    endfunction
endpackage

// ===== hw/rtl/mrpt_if.sv =====
// valid/ready channel interfaces for the prime test block
// depends on mrpt_pkg
interface mrpt_in_if;
    logic valid;
    logic ready;
    mrpt_pkg::word_t number;
    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

interface mrpt_out_if;
    logic valid;
    logic ready;
    logic is_probable_prime;
    modport source (output valid, output is_probable_prime, input ready);
    modport sink (input valid, input is_probable_prime, output ready);
endinterface

// ===== hw/rtl/mrpt_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle (double-and-add)
// depends on mrpt_pkg
module mrpt_mulmod (
    input  logic            clk,
    input  logic            rst_n,
    input  mrpt_pkg::word_t a,
    input  mrpt_pkg::word_t b,
    input  mrpt_pkg::word_t m,
    input  logic            start,
    output mrpt_pkg::mul_ctl_t ctl,
    output mrpt_pkg::word_t result
);
    mrpt_pkg::word_t acc_reg, acc_next, b_reg, b_next;
    logic [mrpt_pkg::BIT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    mrpt_pkg::word_t room, dbl, room_a, add;

    always_comb
    begin
        room = m - acc_reg;
        dbl = (acc_reg >= room) ? (acc_reg - room) : (acc_reg + acc_reg);
        room_a = m - a;
        add = (dbl >= room_a) ? (dbl - room_a) : (dbl + a);
        acc_next = acc_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            b_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = b_reg[mrpt_pkg::WIDTH-1] ? add : dbl;
            b_next = {b_reg[mrpt_pkg::WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg <= b_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign result = acc_reg;
endmodule

// ===== hw/rtl/miller_rabin_prime_test.sv =====
// top level of the miller-rabin prime test: sequencer around a serial mulmod
// depends on mrpt_pkg, mrpt_if, mrpt_mulmod
//
// channel   dir   payload
// in_ch     sink  number (64 bits)
// out_ch    src   is_probable_prime (1 bit)
//
// one transaction at a time; each modular product runs bit-serially in mrpt_mulmod
// a test tries up to 5 bases, each a modular power followed by repeated squaring
// trivial inputs (even, below 4) skip the multiplier: the accept goes to ST_DONE, then to the registered out_ch.valid
// reset clears the sequencer; a held result stalls only the next input
module miller_rabin_prime_test (
    input logic clk,
    input logic rst_n,
    mrpt_in_if.sink in_ch,
    mrpt_out_if.source out_ch
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_SPLIT = 4'd1, ST_BASE = 4'd2,
        ST_PMUL = 4'd3, ST_PWAIT = 4'd4, ST_PSQ = 4'd5, ST_SWAIT = 4'd6,
        ST_CHECK = 4'd7, ST_SQ = 4'd8, ST_SQWAIT = 4'd9, ST_DONE = 4'd10,
        ST_REDUCE = 4'd11;

    logic [3:0] state_reg, state_next;
    mrpt_pkg::word_t n_reg, n_next, d_reg, d_next, e_reg, e_next;
    mrpt_pkg::word_t x_reg, x_next, p_reg, p_next;
    logic [mrpt_pkg::BIT_W-1:0] s_reg, s_next, r_reg, r_next;
    logic [mrpt_pkg::BIDX_W-1:0] bi_reg, bi_next;
    logic res_reg, res_next, ov_reg, ov_next;

    logic mul_start;
    mrpt_pkg::word_t mul_a, mul_b, mul_res, nm1;
    mrpt_pkg::mul_ctl_t mul_ctl;

    mrpt_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .a(mul_a), .b(mul_b), .m(n_reg),
        .start(mul_start), .ctl(mul_ctl), .result(mul_res)
    );

    assign nm1 = n_reg - 1'b1;
    assign in_ch.ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.is_probable_prime = res_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; d_next = d_reg; e_next = e_reg;
        x_next = x_reg; p_next = p_reg; s_next = s_reg; r_next = r_reg;
        bi_next = bi_reg; res_next = res_reg;
        ov_next = ov_reg && !out_ch.ready;
        mul_start = 1'b0;
        mul_a = x_reg;
        mul_b = p_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    n_next = in_ch.number;
                    if (in_ch.number == mrpt_pkg::word_t'(2)
                        || in_ch.number == mrpt_pkg::word_t'(3))
                    begin
                        res_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (in_ch.number < mrpt_pkg::word_t'(2) || !in_ch.number[0])
                    begin
                        res_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next = {in_ch.number[mrpt_pkg::WIDTH-1:1], 1'b0};
                        s_next = '0;
                        res_next = 1'b1;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    bi_next = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                p_next = mrpt_pkg::base_value(4'(bi_reg));
                state_next = ST_REDUCE;
            end
            // base mod n by repeated subtraction
            ST_REDUCE:
            begin
                if (p_reg >= n_reg)
                    p_next = p_reg - n_reg;
                else if (p_reg == '0)
                    state_next = ST_CHECK;
                else
                begin
                    x_next = mrpt_pkg::word_t'(1);
                    e_next = d_reg;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (e_reg == '0)
                begin
                    r_next = mrpt_pkg::BIT_W'(1);
                    if (x_reg == mrpt_pkg::word_t'(1) || x_reg == nm1)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_SQ;
                end
                else if (e_reg[0])
                begin
                    mul_start = 1'b1;
                    state_next = ST_PWAIT;
                end
                else
                begin
                    mul_start = 1'b1;
                    mul_a = p_reg;
                    state_next = ST_SWAIT;
                end
            end
            ST_PWAIT:
            begin
                if (mul_ctl.done)
                begin
                    x_next = mul_res;
                    state_next = ST_PSQ;
                end
            end
            ST_PSQ:
            begin
                mul_start = 1'b1;
                mul_a = p_reg;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                mul_a = p_reg;
                if (mul_ctl.done)
                begin
                    p_next = mul_res;
                    e_next = e_reg >> 1;
                    state_next = ST_PMUL;
                end
            end
            ST_SQ:
            begin
                if (r_reg >= s_reg)
                begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_start = 1'b1;
                    mul_b = x_reg;
                    state_next = ST_SQWAIT;
                end
            end
            ST_SQWAIT:
            begin
                if (mul_ctl.done)
                begin
                    x_next = mul_res;
                    r_next = r_reg + 1'b1;
                    if (mul_res == nm1)
                        state_next = ST_CHECK;
                    else if (mul_res == mrpt_pkg::word_t'(1))
                    begin
                        res_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_SQ;
                end
                else
                    mul_b = x_reg;
            end
            ST_CHECK:
            begin
                if (bi_reg == mrpt_pkg::BIDX_W'(mrpt_pkg::BASE_COUNT-1))
                    state_next = ST_DONE;
                else
                begin
                    bi_next = bi_reg + 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_DONE:
            begin
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; d_reg <= d_next; e_reg <= e_next;
        x_reg <= x_next; p_reg <= p_next; s_reg <= s_next; r_reg <= r_next;
        bi_reg <= bi_next; res_reg <= res_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");
    a_mul_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_ctl.busy)
        else $error("multiplier restarted while busy");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_ch.valid)
        else $error("result not presented");
endmodule
